// ===== src/prw_pkg.sv =====
// shared types and constants of the particle weight resampler
`default_nettype none
package prw_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int WEIGHT_BITS   = 16;
  localparam int FRAC_BITS     = 16;
  localparam int THR_W         = 15;
  localparam int CNT_W         = 7;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CUM_W         = WEIGHT_BITS + IDX_W;
  localparam int SQ_W          = 2 * WEIGHT_BITS + IDX_W;
  localparam int MUL_A_W       = CUM_W;
  localparam int MUL_B_W       = SQ_W;
  localparam int MUL_W         = MUL_A_W + MUL_B_W;
  localparam int LHS_W         = 2 * CUM_W + 8;
  localparam int RHS_W         = THR_W + SQ_W;
  localparam int POS_W         = 2 * CUM_W;
  localparam int SCL_W         = CUM_W + CNT_W;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = THR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEFF_THRESHOLD = 1'd1;

  localparam logic [CNT_W-1:0] COUNT_RESET     = 7'd30;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd3840;

  typedef struct packed {
    logic [15:0] weight;
    logic [15:0] random_offset;
  } in_t;

  typedef struct packed {
    logic [5:0] source_index;
    logic       resampled;
    logic       last_of_run;
  } out_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [CUM_W-1:0] data;
  } wr_t;

endpackage
`default_nettype wire

// ===== src/prw_cum_store.sv =====
// cumulative weight memory, one write and one registered read port
`default_nettype none
module prw_cum_store (
  input  wire logic                      clk,
  input  wire prw_pkg::wr_t              wr,
  input  wire logic [prw_pkg::IDX_W-1:0] rd_addr,
  output logic      [prw_pkg::CUM_W-1:0] rd_data
);

  logic [prw_pkg::CUM_W-1:0] mem [prw_pkg::MAX_PARTICLES];
  logic [prw_pkg::CUM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== src/particle_weight_resampler.sv =====
// top level: weight loading, effective sample size test and systematic resampling
//
// channel   signals                              transfer when
// input     start, busy, in_data                 start high and busy low
// result    out_valid, out_data                  out_valid high, one cycle each
// config    cfg_we, cfg_index, cfg_wdata         cfg_we high
//
// loading takes one weight per cycle with busy low throughout
// the item closing a round starts the test on the shared multiplier
// in states ST_MUL_A, ST_MUL_B and ST_CMP; each resampled index then
// passes ST_POS, ST_SCALE and ST_TEST, with ST_SCALE and ST_TEST again per
// cumulative entry skipped, paced by the single multiplier and the store read
// synchronous active low reset; the store itself is not cleared
// results are strobed for one cycle and cannot be held off
`default_nettype none
module particle_weight_resampler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire prw_pkg::in_t                   in_data,
  output logic                                out_valid,
  output prw_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [prw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [prw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MUL_A = 7'b0000010,
    ST_MUL_B = 7'b0000100,
    ST_CMP   = 7'b0001000,
    ST_POS   = 7'b0010000,
    ST_SCALE = 7'b0100000,
    ST_TEST  = 7'b1000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [prw_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [prw_pkg::THR_W-1:0]       thr_r, thr_nxt;
  logic [prw_pkg::CUM_W-1:0]       total_r, total_nxt;
  logic [prw_pkg::SQ_W-1:0]        sq_r, sq_nxt;
  logic [prw_pkg::CNT_W-1:0]       load_r, load_nxt;
  logic [15:0]                     off_r, off_nxt;
  logic [prw_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic [prw_pkg::IDX_W-1:0]       m_r, m_nxt;
  logic [prw_pkg::MUL_W-1:0]       prod_r;
  logic [prw_pkg::LHS_W-1:0]       lhs_r, lhs_nxt;
  logic [prw_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic                            out_valid_r, out_valid_nxt;
  prw_pkg::out_t                   out_data_r, out_data_nxt;

  logic [prw_pkg::CNT_W-1:0]       n_eff;
  logic [prw_pkg::CNT_W-1:0]       n_last;
  logic [prw_pkg::MUL_A_W-1:0]     mul_a;
  logic [prw_pkg::MUL_B_W-1:0]     mul_b;
  logic [prw_pkg::MUL_W-1:0]       mul_p;
  logic [prw_pkg::WEIGHT_BITS-1:0] w;
  logic [prw_pkg::CUM_W-1:0]       cum_rd;
  logic [prw_pkg::CUM_W-1:0]       stride;
  logic                            accept;
  logic                            advance;
  logic                            is_last;
  prw_pkg::wr_t                    wr;

  always_comb begin
    priority if (count_r == '0) begin
      n_eff = prw_pkg::CNT_W'(1);
    end else if (count_r > prw_pkg::CNT_W'(prw_pkg::MAX_PARTICLES)) begin
      n_eff = prw_pkg::CNT_W'(prw_pkg::MAX_PARTICLES);
    end else begin
      n_eff = count_r;
    end
  end

  assign n_last = n_eff - prw_pkg::CNT_W'(1);
  assign accept = start && (state_r == ST_IDLE);
  assign w      = in_data.weight[prw_pkg::WEIGHT_BITS-1:0];
  assign stride = {m_r, prw_pkg::FRAC_BITS'(0)} + prw_pkg::CUM_W'(off_r);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_IDLE: begin
        mul_a = prw_pkg::MUL_A_W'(w);
        mul_b = prw_pkg::MUL_B_W'(w);
      end
      ST_MUL_A: begin
        mul_a = total_r;
        mul_b = prw_pkg::MUL_B_W'(total_r);
      end
      ST_MUL_B: begin
        mul_a = prw_pkg::MUL_A_W'(thr_r);
        mul_b = sq_r;
      end
      ST_POS: begin
        mul_a = stride;
        mul_b = prw_pkg::MUL_B_W'(total_r);
      end
      ST_SCALE: begin
        mul_a = cum_rd;
        mul_b = prw_pkg::MUL_B_W'(n_eff);
      end
      ST_CMP, ST_TEST: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = prw_pkg::MUL_W'(mul_a) * prw_pkg::MUL_W'(mul_b);

  assign advance = (prw_pkg::CNT_W'(idx_r) < n_last) &&
                   ({1'b0, pos_r} >
                    {prod_r[prw_pkg::SCL_W-1:0], prw_pkg::FRAC_BITS'(0)});
  assign is_last = (prw_pkg::CNT_W'(m_r) == n_last);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    thr_nxt       = thr_r;
    total_nxt     = total_r;
    sq_nxt        = sq_r;
    load_nxt      = load_r;
    off_nxt       = off_r;
    idx_nxt       = idx_r;
    m_nxt         = m_r;
    lhs_nxt       = lhs_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr.en         = 1'b0;
    wr.addr       = load_r[prw_pkg::IDX_W-1:0];
    wr.data       = total_r + prw_pkg::CUM_W'(w);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          total_nxt = total_r + prw_pkg::CUM_W'(w);
          sq_nxt    = sq_r + mul_p[prw_pkg::SQ_W-1:0];
          load_nxt  = load_r + prw_pkg::CNT_W'(1);
          wr.en     = 1'b1;
          if (load_nxt >= n_eff) begin
            off_nxt   = in_data.random_offset;
            state_nxt = ST_MUL_A;
          end
        end
      end
      ST_MUL_A: begin
        state_nxt = ST_MUL_B;
      end
      ST_MUL_B: begin
        lhs_nxt   = {prod_r[prw_pkg::LHS_W-9:0], 8'd0};
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (prw_pkg::RHS_W'(lhs_r) < prod_r[prw_pkg::RHS_W-1:0]) begin
          idx_nxt   = '0;
          m_nxt     = '0;
          state_nxt = ST_POS;
        end else begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.source_index = '0;
          out_data_nxt.resampled    = 1'b0;
          out_data_nxt.last_of_run  = 1'b1;
          total_nxt                 = '0;
          sq_nxt                    = '0;
          load_nxt                  = '0;
          state_nxt                 = ST_IDLE;
        end
      end
      ST_POS: begin
        pos_nxt   = mul_p[prw_pkg::POS_W-1:0];
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (advance) begin
          idx_nxt   = idx_r + prw_pkg::IDX_W'(1);
          state_nxt = ST_SCALE;
        end else begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.source_index = 6'(idx_r);
          out_data_nxt.resampled    = 1'b1;
          out_data_nxt.last_of_run  = is_last;
          if (is_last) begin
            total_nxt = '0;
            sq_nxt    = '0;
            load_nxt  = '0;
            state_nxt = ST_IDLE;
          end else begin
            m_nxt     = m_r + prw_pkg::IDX_W'(1);
            state_nxt = ST_POS;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        prw_pkg::CFG_PARTICLE_COUNT: begin
          count_nxt = cfg_wdata[prw_pkg::CNT_W-1:0];
          total_nxt = '0;
          sq_nxt    = '0;
          load_nxt  = '0;
        end
        prw_pkg::CFG_NEFF_THRESHOLD: begin
          thr_nxt = cfg_wdata[prw_pkg::THR_W-1:0];
        end
        default: begin
          thr_nxt = thr_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= prw_pkg::COUNT_RESET;
      thr_r       <= prw_pkg::THRESHOLD_RESET;
      total_r     <= '0;
      sq_r        <= '0;
      load_r      <= '0;
      off_r       <= '0;
      idx_r       <= '0;
      m_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      thr_r       <= thr_nxt;
      total_r     <= total_nxt;
      sq_r        <= sq_nxt;
      load_r      <= load_nxt;
      off_r       <= off_nxt;
      idx_r       <= idx_nxt;
      m_r         <= m_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= mul_p;
    lhs_r      <= lhs_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  prw_cum_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (idx_nxt),
    .rd_data (cum_rd)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== src/prw_checker.sv =====
// port level checks of the particle weight resampler and their binding
`default_nettype none
module prw_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          busy,
  input wire logic          out_valid,
  input wire prw_pkg::out_t out_data
);

  // results only come out of a round that was being worked on
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without preceding busy");

  // the no-resample result is always a lone final index zero
  a_no_resample_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.resampled) |->
      (out_data.last_of_run && (out_data.source_index == '0)))
    else $error("malformed no-resample result");

  // more results pending keeps the block busy
  a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_of_run) |-> busy)
    else $error("not busy in the middle of a run");

  // a round closes with a gap before any further result
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_of_run) |=> !out_valid)
    else $error("result straight after end of run");

endmodule

bind particle_weight_resampler prw_checker u_prw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
